// ===== hw/rtl/rnra_pkg.sv =====
`timescale 1ns / 1ps

package rnra_pkg;

  // Ring geometry
  localparam int MAX_SEATS = 8;
  localparam int SEAT_W    = 3;
  localparam int RING_W    = 4;

  // Result list: at most four results for one item
  localparam int RES_CAP   = 4;
  localparam int RIDX_W    = 2;
  localparam int RCNT_W    = 3;

  // Microcode program counter
  localparam int PC_W      = 4;

  // Result status codes
  localparam logic [1:0] ST_GRANT = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_NONE  = 2'd2;

  // Datapath operation selected by a control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_FETCH,
    OP_ACQ,
    OP_CLR,
    OP_LEFT,
    OP_RIGHT,
    OP_SCAN,
    OP_NONE,
    OP_EMIT
  } op_t;

  // Jump condition selected by a control word
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_REL,
    C_LEFT_OK,
    C_RIGHT_OK,
    C_SCAN_MORE,
    C_EMIT_PEND
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            ret;
  } ctl_word_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic cmd_rel;
    logic left_ok;
    logic right_ok;
    logic scan_more;
    logic emit_pend;
  } flags_t;

endpackage

// ===== hw/rtl/rnra_seq.sv =====
`timescale 1ns / 1ps

module rnra_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  rnra_pkg::flags_t flags,
  output rnra_pkg::op_t   op
);
  import rnra_pkg::*;

  // Program step addresses
  localparam logic [PC_W-1:0] S_FETCH  = 4'd0;
  localparam logic [PC_W-1:0] S_DECODE = 4'd1;
  localparam logic [PC_W-1:0] S_ACQ    = 4'd2;
  localparam logic [PC_W-1:0] S_REL    = 4'd3;
  localparam logic [PC_W-1:0] S_LEFT   = 4'd4;
  localparam logic [PC_W-1:0] S_RIGHT  = 4'd5;
  localparam logic [PC_W-1:0] S_SCAN   = 4'd6;
  localparam logic [PC_W-1:0] S_NONE   = 4'd7;
  localparam logic [PC_W-1:0] S_EMIT   = 4'd8;

  // Control store
  function automatic ctl_word_t rom(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_FETCH, ret: 1'b1};
    unique case (pc)
      S_FETCH:  w = '{op: OP_FETCH, cond: C_NO_INPUT,  target: S_FETCH, ret: 1'b0};
      S_DECODE: w = '{op: OP_NOP,   cond: C_REL,       target: S_REL,   ret: 1'b0};
      S_ACQ:    w = '{op: OP_ACQ,   cond: C_ALWAYS,    target: S_EMIT,  ret: 1'b0};
      S_REL:    w = '{op: OP_CLR,   cond: C_NEVER,     target: S_FETCH, ret: 1'b0};
      S_LEFT:   w = '{op: OP_LEFT,  cond: C_LEFT_OK,   target: S_EMIT,  ret: 1'b0};
      S_RIGHT:  w = '{op: OP_RIGHT, cond: C_RIGHT_OK,  target: S_EMIT,  ret: 1'b0};
      S_SCAN:   w = '{op: OP_SCAN,  cond: C_SCAN_MORE, target: S_SCAN,  ret: 1'b0};
      S_NONE:   w = '{op: OP_NONE,  cond: C_NEVER,     target: S_FETCH, ret: 1'b0};
      S_EMIT:   w = '{op: OP_EMIT,  cond: C_EMIT_PEND, target: S_EMIT,  ret: 1'b1};
      default:  w = '{op: OP_NOP,   cond: C_ALWAYS,    target: S_FETCH, ret: 1'b1};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  ctl_word_t       cw;
  logic            take;

  assign cw = rom(pc_r);
  assign op = cw.op;

  // Select the jump condition
  always_comb begin
    unique case (cw.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_INPUT:  take = !flags.in_valid;
      C_REL:       take = flags.cmd_rel;
      C_LEFT_OK:   take = flags.left_ok;
      C_RIGHT_OK:  take = flags.right_ok;
      C_SCAN_MORE: take = flags.scan_more;
      C_EMIT_PEND: take = flags.emit_pend;
      default:     take = 1'b0;
    endcase
  end

  // Jump, fall through, or return to fetch
  always_comb begin
    if (take) begin
      pc_nxt = cw.target;
    end else if (cw.ret) begin
      pc_nxt = S_FETCH;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hw/rtl/ring_neighbour_resource_arbiter.sv =====
`timescale 1ns / 1ps
// Channel  | Dir | Ports                          | Contents
// in_      | in  | tvalid tready tdata tuser      | seat request or release
// out_     | out | tvalid tready tdata tuser tlast| grant, wait or no-grant result
// cfg_     | in  | wr_en wr_data                  | seats_in_use
//
// Each item runs through a microcode program, one control word per cycle.
// Acquire: decode and acquire steps follow the accept; the emit step then loads the result.
// Release: the seat is cleared, then the left and after it the right neighbour is offered the grant;
// a full scan over the n seats (no-grant result if none found) runs when neither takes it.
// The seat scan steps one seat per cycle; one result leaves per cycle, held while out_tready is low.
// Reset (synchronous, rst_n low) clears busy and waiting bits and sets seats_in_use to 5.

module ring_neighbour_resource_arbiter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [2:0] seat
  input  logic       in_tuser,   // [0] command
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] granted_seat
  output logic [1:0] out_tuser,  // [1:0] status
  output logic       out_tlast,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);
  import rnra_pkg::*;

  // Ring neighbours
  function automatic logic [SEAT_W-1:0] left_of(input logic [SEAT_W-1:0] s,
                                                input logic [SEAT_W-1:0] nm1);
    return (s == '0) ? nm1 : SEAT_W'(s - 1'b1);
  endfunction

  function automatic logic [SEAT_W-1:0] right_of(input logic [SEAT_W-1:0] s,
                                                 input logic [SEAT_W-1:0] nm1);
    return (s == nm1) ? '0 : SEAT_W'(s + 1'b1);
  endfunction

  // Seat index modulo the ring size (n >= 3, so two subtracts suffice)
  function automatic logic [SEAT_W-1:0] seat_mod(input logic [SEAT_W-1:0] s,
                                                 input logic [RING_W-1:0] n);
    logic [RING_W-1:0] t;
    t = {1'b0, s};
    if (t >= n) t = t - n;
    if (t >= n) t = t - n;
    return t[SEAT_W-1:0];
  endfunction

  op_t    op;
  flags_t flags;

  logic [3:0]           seats_r;
  logic [RING_W-1:0]    ring_n;
  logic [SEAT_W-1:0]    nm1;

  logic [MAX_SEATS-1:0] busy_r, busy_nxt;
  logic [MAX_SEATS-1:0] wait_r, wait_nxt;
  logic [SEAT_W-1:0]    seat_r, seat_nxt;
  logic                 rel_r, rel_nxt;
  logic [SEAT_W-1:0]    idx_r, idx_nxt;
  logic [RCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [RIDX_W-1:0]    eidx_r, eidx_nxt;

  logic [SEAT_W-1:0]    res_seat_r [RES_CAP];
  logic [1:0]           res_st_r   [RES_CAP];

  logic                 out_valid_r, out_valid_nxt;
  logic [SEAT_W-1:0]    out_seat_r;
  logic [1:0]           out_st_r;
  logic                 out_last_r;

  logic                 push;
  logic [1:0]           push_st;
  logic [SEAT_W-1:0]    push_seat;

  logic [SEAT_W-1:0]    s_l, s_r, l_l, r_r, i_l, i_r;
  logic                 left_ok, right_ok, scan_ok;
  logic                 load, is_last;

  // Saturate the ring size to [3, MAX_SEATS]
  always_comb begin
    if (seats_r < 4'd3) begin
      ring_n = 4'd3;
    end else if (seats_r > RING_W'(MAX_SEATS)) begin
      ring_n = RING_W'(MAX_SEATS);
    end else begin
      ring_n = seats_r;
    end
  end
  assign nm1 = SEAT_W'(ring_n - 4'd1);

  // Neighbour tests
  assign s_l      = left_of(seat_r, nm1);
  assign s_r      = right_of(seat_r, nm1);
  assign l_l      = left_of(s_l, nm1);
  assign r_r      = right_of(s_r, nm1);
  assign i_l      = left_of(idx_r, nm1);
  assign i_r      = right_of(idx_r, nm1);
  assign left_ok  = wait_r[s_l] && !busy_r[l_l];
  assign right_ok = wait_r[s_r] && !busy_r[r_r];
  assign scan_ok  = wait_r[idx_r] && !busy_r[i_l] && !busy_r[i_r]
                    && (cnt_r < RCNT_W'(RES_CAP));

  // Output register load
  assign is_last = ({1'b0, eidx_r} == RCNT_W'(cnt_r - 1'b1));
  assign load    = (op == OP_EMIT) && (!out_valid_r || out_tready);

  assign flags.in_valid  = in_tvalid;
  assign flags.cmd_rel   = rel_r;
  assign flags.left_ok   = left_ok;
  assign flags.right_ok  = right_ok;
  assign flags.scan_more = (idx_r != nm1);
  assign flags.emit_pend = !(load && is_last);

  rnra_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  assign in_tready = (op == OP_FETCH);

  // Datapath actions for the current control word
  always_comb begin
    busy_nxt  = busy_r;
    wait_nxt  = wait_r;
    seat_nxt  = seat_r;
    rel_nxt   = rel_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    eidx_nxt  = eidx_r;
    push      = 1'b0;
    push_st   = ST_GRANT;
    push_seat = '0;
    unique case (op)
      OP_FETCH: begin
        if (in_tvalid) begin
          seat_nxt = seat_mod(in_tdata[SEAT_W-1:0], ring_n);
          rel_nxt  = in_tuser;
          idx_nxt  = '0;
          cnt_nxt  = '0;
          eidx_nxt = '0;
        end
      end
      OP_ACQ: begin
        push = 1'b1;
        if (busy_r[seat_r]) begin
          push_seat = seat_r;
        end else if (!busy_r[s_l] && !busy_r[s_r]) begin
          busy_nxt[seat_r] = 1'b1;
          wait_nxt[seat_r] = 1'b0;
          push_seat        = seat_r;
        end else begin
          wait_nxt[seat_r] = 1'b1;
          push_st          = ST_WAIT;
        end
      end
      OP_CLR: begin
        busy_nxt[seat_r] = 1'b0;
      end
      OP_LEFT: begin
        if (left_ok) begin
          busy_nxt[s_l] = 1'b1;
          wait_nxt[s_l] = 1'b0;
          push          = 1'b1;
          push_seat     = s_l;
        end
      end
      OP_RIGHT: begin
        if (right_ok) begin
          busy_nxt[s_r] = 1'b1;
          wait_nxt[s_r] = 1'b0;
          push          = 1'b1;
          push_seat     = s_r;
        end
      end
      OP_SCAN: begin
        idx_nxt = SEAT_W'(idx_r + 1'b1);
        if (scan_ok) begin
          busy_nxt[idx_r] = 1'b1;
          wait_nxt[idx_r] = 1'b0;
          push            = 1'b1;
          push_seat       = idx_r;
        end
      end
      OP_NONE: begin
        if (cnt_r == '0) begin
          push    = 1'b1;
          push_st = ST_NONE;
        end
      end
      OP_EMIT: begin
        if (load) begin
          eidx_nxt = RIDX_W'(eidx_r + 1'b1);
        end
      end
      default: begin
      end
    endcase
    if (push) begin
      cnt_nxt = RCNT_W'(cnt_r + 1'b1);
    end
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seats_r     <= 4'd5;
      busy_r      <= '0;
      wait_r      <= '0;
      rel_r       <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
      eidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seats_r <= cfg_wr_data;
      end
      busy_r      <= busy_nxt;
      wait_r      <= wait_nxt;
      rel_r       <= rel_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      eidx_r      <= eidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: seat, result list, output
  always_ff @(posedge clk) begin
    seat_r <= seat_nxt;
    if (push) begin
      res_seat_r[cnt_r[RIDX_W-1:0]] <= push_seat;
      res_st_r[cnt_r[RIDX_W-1:0]]   <= push_st;
    end
    if (load) begin
      out_seat_r <= res_seat_r[eidx_r];
      out_st_r   <= res_st_r[eidx_r];
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(8 - SEAT_W){1'b0}}, out_seat_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

endmodule
